@@ hw/rtl/rmq_pkg.sv @@
// Shared types and constants for the rotation matrix to quaternion unit.
package rmq_pkg;

  typedef enum logic [1:0] {
    IDX_W = 2'd0,
    IDX_X = 2'd1,
    IDX_Y = 2'd2,
    IDX_Z = 2'd3
  } idx_t;

  localparam int NUM_LANES = 3;

endpackage

@@ hw/rtl/rmq_front.sv @@
// Front stage: diagonal candidates, largest pick, off-diagonal terms, sqrt operand.
module rmq_front
  import rmq_pkg::*;
#(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_i,
  input  logic [9*W-1:0]        m_i,
  output logic                  valid_r,
  output logic [2*W-1:0]        x_r,
  output logic [3*(W+1)-1:0]    d_r,
  output idx_t                  idx_r
);

  localparam int FRAC = W - 2;
  localparam int CW = W + 2;

  logic signed [CW-1:0] m [9];
  logic signed [CW-1:0] cand [4];
  logic signed [CW-1:0] big;
  logic signed [W:0]    t57m, t62m, t13m, t13p, t62p, t57p;
  logic signed [W:0]    d0, d1, d2;
  logic [W:0]           s;
  idx_t                 idx;
  logic                 valid_nxt;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m[i] = CW'($signed(m_i[i*W +: W]));
    end
    cand[0] = m[0] + m[4] + m[8];
    cand[1] = m[0] - m[4] - m[8];
    cand[2] = m[4] - m[0] - m[8];
    cand[3] = m[8] - m[0] - m[4];
    big = cand[0];
    idx = IDX_W;
    if (cand[1] > big) begin
      big = cand[1];
      idx = IDX_X;
    end
    if (cand[2] > big) begin
      big = cand[2];
      idx = IDX_Y;
    end
    if (cand[3] > big) begin
      big = cand[3];
      idx = IDX_Z;
    end
    if (big < 0) begin
      big = '0;
    end
    s = (W+1)'(big) + ((W+1)'(1) << FRAC);
    t57m = m[5][W:0] - m[7][W:0];
    t62m = m[6][W:0] - m[2][W:0];
    t13m = m[1][W:0] - m[3][W:0];
    t13p = m[1][W:0] + m[3][W:0];
    t62p = m[6][W:0] + m[2][W:0];
    t57p = m[5][W:0] + m[7][W:0];
    unique case (idx)
      IDX_W: begin
        d0 = t57m; d1 = t62m; d2 = t13m;
      end
      IDX_X: begin
        d0 = t57m; d1 = t13p; d2 = t62p;
      end
      IDX_Y: begin
        d0 = t62m; d1 = t13p; d2 = t57p;
      end
      default: begin
        d0 = t13m; d1 = t62p; d2 = t57p;
      end
    endcase
  end

  assign valid_nxt = valid_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= {1'b0, s, {FRAC{1'b0}}};
      d_r   <= {d2, d1, d0};
      idx_r <= idx;
    end
  end

endmodule

@@ hw/rtl/rmq_sqrt_step.sv @@
// One registered step of the digit-by-digit integer square root.
module rmq_sqrt_step #(
  parameter int W = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [2*W-1:0]    x_i,
  input  logic [W+2:0]      rem_i,
  input  logic [W-1:0]      root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_r,
  output logic [2*W-1:0]    x_r,
  output logic [W+2:0]      rem_r,
  output logic [W-1:0]      root_r,
  output logic [SIDE_W-1:0] side_r
);

  logic [W+2:0] rem_sh;
  logic [W+2:0] trial;
  logic         ge;
  logic [W+2:0] rem_nxt;
  logic [W-1:0] root_nxt;

  always_comb begin
    rem_sh   = {rem_i[W:0], x_i[2*W-1:2*W-2]};
    trial    = {1'b0, root_i, 2'b01};
    ge       = rem_sh >= trial;
    rem_nxt  = ge ? rem_sh - trial : rem_sh;
    root_nxt = {root_i[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= {x_i[2*W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

endmodule

@@ hw/rtl/rmq_div_step.sv @@
// One registered restoring division step for the three off-diagonal lanes.
module rmq_div_step
  import rmq_pkg::*;
#(
  parameter int W = 16,
  parameter int SIDE_W = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      valid_i,
  input  logic [W:0]                den_i,
  input  logic [NUM_LANES-1:0][W:0] rem_i,
  input  logic [NUM_LANES-1:0][W:0] num_i,
  input  logic [NUM_LANES-1:0][W:0] q_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_r,
  output logic [W:0]                den_r,
  output logic [NUM_LANES-1:0][W:0] rem_r,
  output logic [NUM_LANES-1:0][W:0] num_r,
  output logic [NUM_LANES-1:0][W:0] q_r,
  output logic [SIDE_W-1:0]         side_r
);

  logic [W+1:0]                r2 [NUM_LANES];
  logic [NUM_LANES-1:0]        ge;
  logic [NUM_LANES-1:0][W:0]   rem_nxt;
  logic [NUM_LANES-1:0][W:0]   q_nxt;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      r2[i]      = {rem_i[i], num_i[i][W]};
      ge[i]      = r2[i] >= {1'b0, den_i};
      rem_nxt[i] = ge[i] ? (W+1)'(r2[i] - {1'b0, den_i}) : r2[i][W:0];
      q_nxt[i]   = {q_i[i][W-1:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den_i;
      rem_r <= rem_nxt;
      for (int i = 0; i < NUM_LANES; i++) begin
        num_r[i] <= {num_i[i][W-1:0], 1'b0};
      end
      q_r    <= q_nxt;
      side_r <= side_i;
    end
  end

endmodule

@@ hw/rtl/rotation_matrix_to_quaternion_unit.sv @@
// Top level of the rotation matrix to quaternion unit (Shepperd's method).
//
//   Channel | Direction | Contents
//   in_     | slave     | nine matrix elements m00..m22 in tdata
//   out_    | master    | qw qx qy qz in tdata, largest_index in tuser
//
// The pipeline has one front stage, DATA_WIDTH square root steps, one setup
// stage, DATA_WIDTH+1 division steps and one output stage. One transfer is
// accepted every cycle while the output is not stalled. Reset clears the
// valid bits only. When the output holds a transfer that is not taken, the
// whole pipeline stops and keeps its contents.
module rotation_matrix_to_quaternion_unit
  import rmq_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up.
  input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // qw, qx, qy, qz from the lowest bit up.
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]   out_tdata,
  // largest_index.
  output logic [7:0]                          out_tuser
);

  localparam int W = DATA_WIDTH;
  localparam int FRAC = W - 2;
  localparam int OUT_TW = ((4*W+7)/8)*8;
  localparam int SQ_SIDE = 3*(W+1) + 2;
  localparam int DV_SIDE = 3 + 2 + (W-1);
  localparam logic [W:0] SMAX = {2'b00, {(W-1){1'b1}}};
  localparam logic [W:0] SMIN_MAG = {2'b01, {(W-1){1'b0}}};

  logic en;

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  logic               f_valid;
  logic [2*W-1:0]     f_x;
  logic [3*(W+1)-1:0] f_d;
  idx_t               f_idx;

  rmq_front #(.W(W)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(in_tvalid && in_tready),
    .m_i(in_tdata[9*W-1:0]),
    .valid_r(f_valid), .x_r(f_x), .d_r(f_d), .idx_r(f_idx)
  );

  logic               sq_v    [W+1];
  logic [2*W-1:0]     sq_x    [W+1];
  logic [W+2:0]       sq_rem  [W+1];
  logic [W-1:0]       sq_root [W+1];
  logic [SQ_SIDE-1:0] sq_side [W+1];

  assign sq_v[0]    = f_valid;
  assign sq_x[0]    = f_x;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {f_idx, f_d};

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    rmq_sqrt_step #(.W(W), .SIDE_W(SQ_SIDE)) u_step (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_i(sq_v[k]), .x_i(sq_x[k]), .rem_i(sq_rem[k]),
      .root_i(sq_root[k]), .side_i(sq_side[k]),
      .valid_r(sq_v[k+1]), .x_r(sq_x[k+1]), .rem_r(sq_rem[k+1]),
      .root_r(sq_root[k+1]), .side_r(sq_side[k+1])
    );
  end

  logic signed [W:0]          s_d [NUM_LANES];
  logic [W:0]                 s_mag [NUM_LANES];
  logic [2*W-1:0]             s_num [NUM_LANES];
  logic [W-2:0]               s_c;
  logic [W:0]                 s_den;
  logic                       p_valid_r;
  logic [W:0]                 p_den_r;
  logic [NUM_LANES-1:0][W:0]  p_rem_r;
  logic [NUM_LANES-1:0][W:0]  p_num_r;
  logic [DV_SIDE-1:0]         p_side_r;
  logic [NUM_LANES-1:0]       s_neg;

  always_comb begin
    s_c   = sq_root[W][W-1:1];
    s_den = {s_c, 2'b00};
    for (int i = 0; i < NUM_LANES; i++) begin
      s_d[i]   = $signed(sq_side[W][i*(W+1) +: W+1]);
      s_neg[i] = s_d[i][W];
      s_mag[i] = s_neg[i] ? (W+1)'(-s_d[i]) : s_d[i];
      s_num[i] = ((2*W)'(s_mag[i]) << FRAC) + (2*W)'(s_den >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= sq_v[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_den_r <= s_den;
      for (int i = 0; i < NUM_LANES; i++) begin
        p_rem_r[i] <= (W+1)'(s_num[i][2*W-1:W+1]);
        p_num_r[i] <= s_num[i][W:0];
      end
      p_side_r <= {s_c, sq_side[W][SQ_SIDE-1 -: 2], s_neg};
    end
  end

  logic                      dv_v    [W+2];
  logic [W:0]                dv_den  [W+2];
  logic [NUM_LANES-1:0][W:0] dv_rem  [W+2];
  logic [NUM_LANES-1:0][W:0] dv_num  [W+2];
  logic [NUM_LANES-1:0][W:0] dv_q    [W+2];
  logic [DV_SIDE-1:0]        dv_side [W+2];

  assign dv_v[0]    = p_valid_r;
  assign dv_den[0]  = p_den_r;
  assign dv_rem[0]  = p_rem_r;
  assign dv_num[0]  = p_num_r;
  assign dv_q[0]    = '0;
  assign dv_side[0] = p_side_r;

  for (genvar k = 0; k < W+1; k++) begin : g_div
    rmq_div_step #(.W(W), .SIDE_W(DV_SIDE)) u_step (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_i(dv_v[k]), .den_i(dv_den[k]), .rem_i(dv_rem[k]),
      .num_i(dv_num[k]), .q_i(dv_q[k]), .side_i(dv_side[k]),
      .valid_r(dv_v[k+1]), .den_r(dv_den[k+1]), .rem_r(dv_rem[k+1]),
      .num_r(dv_num[k+1]), .q_r(dv_q[k+1]), .side_r(dv_side[k+1])
    );
  end

  logic [W-1:0]  lane_val [NUM_LANES];
  logic [W-1:0]  comp [4];
  idx_t          o_idx;
  logic [W-2:0]  o_c;
  logic [W:0]    qv;
  logic [W-1:0]  out_q_nxt [4];
  logic [1:0]    out_idx_r;
  logic [W-1:0]  out_q_r [4];
  logic          out_valid_r;
  logic [W-1:0]  chosen_q;

  always_comb begin
    o_idx = idx_t'(dv_side[W+1][4:3]);
    o_c   = dv_side[W+1][DV_SIDE-1 -: W-1];
    for (int i = 0; i < NUM_LANES; i++) begin
      qv = dv_q[W+1][i];
      if (!dv_side[W+1][i]) begin
        lane_val[i] = (qv > SMAX) ? SMAX[W-1:0] : qv[W-1:0];
      end else begin
        lane_val[i] = (qv > SMIN_MAG) ? SMIN_MAG[W-1:0] : W'(-qv);
      end
    end
    unique case (o_idx)
      IDX_W: begin
        comp[0] = {1'b0, o_c}; comp[1] = lane_val[0];
        comp[2] = lane_val[1]; comp[3] = lane_val[2];
      end
      IDX_X: begin
        comp[0] = lane_val[0]; comp[1] = {1'b0, o_c};
        comp[2] = lane_val[1]; comp[3] = lane_val[2];
      end
      IDX_Y: begin
        comp[0] = lane_val[0]; comp[1] = lane_val[1];
        comp[2] = {1'b0, o_c}; comp[3] = lane_val[2];
      end
      default: begin
        comp[0] = lane_val[0]; comp[1] = lane_val[1];
        comp[2] = lane_val[2]; comp[3] = {1'b0, o_c};
      end
    endcase
    for (int j = 0; j < 4; j++) begin
      out_q_nxt[j] = comp[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v[W+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_idx_r <= o_idx;
      for (int j = 0; j < 4; j++) begin
        out_q_r[j] <= out_q_nxt[j];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'({out_q_r[3], out_q_r[2], out_q_r[1], out_q_r[0]});
  assign out_tuser  = {6'b0, out_idx_r};
  assign chosen_q   = out_q_r[out_idx_r];

  a_chosen_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (chosen_q >= W'(1 << (FRAC-1))) && !chosen_q[W-1])
    else $error("chosen component below one half");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(f_valid) && $stable(p_valid_r))
    else $error("pipeline moved during a stall");

endmodule

@@ tb/rotation_matrix_to_quaternion_unit_tb.sv @@
// Self-checking testbench for the rotation matrix to quaternion unit.
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_unit_tb;
  import rmq_pkg::*;

  localparam int DW = 16;
  localparam int FRAC = DW - 2;
  localparam int IN_W = ((9 * DW + 7) / 8) * 8;
  localparam int OUT_W = ((4 * DW + 7) / 8) * 8;
  localparam int LATENCY = 2 * DW + 4;
  localparam int NUM_RANDOM = 430;

  typedef logic signed [DW-1:0] elem_t;
  typedef struct {
    elem_t q[4];
    idx_t  idx;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [7:0] out_tuser;

  logic [IN_W-1:0] pending_mats[$];
  quat_t expected_quats[$];
  int errors = 0;
  int matched = 0;
  int sent = 0;
  int wait_cnt = 0;
  int stall_cnt = 0;
  int hold_cnt = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;
  int branch_seen[4] = '{0, 0, 0, 0};
  logic in_tready_s = 1'b0;
  logic out_xfer_s = 1'b0;

  rotation_matrix_to_quaternion_unit #(.DATA_WIDTH(DW)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  function automatic longint clamp(longint v);
    longint hi;
    hi = (longint'(1) <<< (DW - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint root_floor(longint x);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r + (longint'(1) <<< b)) * (r + (longint'(1) <<< b)) <= x)
        r = r + (longint'(1) <<< b);
    end
    return r;
  endfunction

  function automatic longint off_term(longint d, longint c);
    longint mag;
    longint den;
    longint qv;
    mag = (d < 0) ? -d : d;
    den = 4 * c;
    qv = ((mag <<< FRAC) + (den >>> 1)) / den;
    return clamp((d < 0) ? -qv : qv);
  endfunction

  function automatic quat_t matrix_to_quat(logic [IN_W-1:0] data);
    longint m[9];
    longint cand[4];
    longint big;
    longint c;
    longint t[4];
    int k;
    quat_t r;
    for (int i = 0; i < 9; i++) m[i] = longint'(elem_t'(data[i*DW +: DW]));
    cand[0] = m[0] + m[4] + m[8];
    cand[1] = m[0] - m[4] - m[8];
    cand[2] = m[4] - m[0] - m[8];
    cand[3] = m[8] - m[0] - m[4];
    big = cand[0];
    k = 0;
    for (int i = 1; i < 4; i++) begin
      if (cand[i] > big) begin
        big = cand[i];
        k = i;
      end
    end
    if (big < 0) big = 0;
    c = root_floor((big + (longint'(1) <<< FRAC)) <<< FRAC) >>> 1;
    t[k] = clamp(c);
    case (k)
      0: begin
        t[1] = off_term(m[5] - m[7], c);
        t[2] = off_term(m[6] - m[2], c);
        t[3] = off_term(m[1] - m[3], c);
      end
      1: begin
        t[0] = off_term(m[5] - m[7], c);
        t[2] = off_term(m[1] + m[3], c);
        t[3] = off_term(m[6] + m[2], c);
      end
      2: begin
        t[0] = off_term(m[6] - m[2], c);
        t[1] = off_term(m[1] + m[3], c);
        t[3] = off_term(m[5] + m[7], c);
      end
      default: begin
        t[0] = off_term(m[1] - m[3], c);
        t[1] = off_term(m[6] + m[2], c);
        t[2] = off_term(m[5] + m[7], c);
      end
    endcase
    for (int i = 0; i < 4; i++) r.q[i] = elem_t'(t[i]);
    r.idx = idx_t'(k);
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_matrix(longint m[9]);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*DW +: DW] = elem_t'(m[i]);
    return d;
  endfunction

  // Near-rotation matrices: a scaled diagonal picks a branch, uniform noise in [-one, one] elsewhere.
  function automatic logic [IN_W-1:0] rotation_like(int branch);
    longint m[9];
    longint one;
    one = longint'(1) <<< FRAC;
    for (int i = 0; i < 9; i++) m[i] = $signed($urandom_range(0, 2 * one)) - one;
    m[0] = $signed($urandom_range(0, 2 * one)) - one;
    m[4] = $signed($urandom_range(0, 2 * one)) - one;
    m[8] = $signed($urandom_range(0, 2 * one)) - one;
    if (branch > 0) m[(branch - 1) * 4] = one - $urandom_range(0, one / 4);
    else begin
      m[0] = one - $urandom_range(0, one / 4);
      m[4] = one - $urandom_range(0, one / 4);
      m[8] = one - $urandom_range(0, one / 4);
    end
    return pack_matrix(m);
  endfunction

  initial begin
    longint m[9];
    longint one;
    one = longint'(1) <<< FRAC;
    pending_mats.push_back('0);
    pending_mats.push_back({IN_W{1'b1}});
    for (int i = 0; i < 9; i++) m[i] = 32767;
    pending_mats.push_back(pack_matrix(m));
    for (int i = 0; i < 9; i++) m[i] = -32768;
    pending_mats.push_back(pack_matrix(m));
    for (int i = 0; i < 9; i++) m[i] = (i % 2) ? -32768 : 32767;
    pending_mats.push_back(pack_matrix(m));
    for (int i = 0; i < 9; i++) m[i] = (i % 2) ? 32767 : -32768;
    pending_mats.push_back(pack_matrix(m));
    // Identity and the three half-turn rotations select each branch.
    for (int b = 0; b < 4; b++) begin
      for (int i = 0; i < 9; i++) m[i] = 0;
      m[0] = (b == 0 || b == 1) ? one : -one;
      m[4] = (b == 0 || b == 2) ? one : -one;
      m[8] = (b == 0 || b == 3) ? one : -one;
      pending_mats.push_back(pack_matrix(m));
    end
    // Ties between candidates: the earliest one must win.
    for (int i = 0; i < 9; i++) m[i] = 0;
    m[0] = one;
    pending_mats.push_back(pack_matrix(m));
    m[0] = 0;
    m[4] = one;
    m[8] = one;
    pending_mats.push_back(pack_matrix(m));
    for (int i = 0; i < 9; i++) m[i] = 0;
    m[4] = one;
    pending_mats.push_back(pack_matrix(m));
    // Off-diagonal extremes exercise the derived components.
    for (int b = 0; b < 4; b++) begin
      for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 0 : ((i % 2) ? 32767 : -32768);
      if (b > 0) m[(b - 1) * 4] = 32767;
      pending_mats.push_back(pack_matrix(m));
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if ($urandom_range(0, 9) < 7) pending_mats.push_back(rotation_like($urandom_range(0, 3)));
      else begin
        for (int i = 0; i < 9; i++) m[i] = $signed(16'($urandom));
        pending_mats.push_back(pack_matrix(m));
      end
    end
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  // Sender.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready_s) begin
        if (wait_cnt == 0 && pending_mats.size() > 0) begin
          in_tdata <= pending_mats.pop_front();
          wait_cnt <= (sent % 100 < 30) ? 0 : $urandom_range(0, 16);
        end else begin
          in_tvalid <= 1'b0;
        end
      end else if (!in_tvalid) begin
        if (wait_cnt > 0) wait_cnt <= wait_cnt - 1;
        else if (pending_mats.size() > 0) begin
          in_tdata <= pending_mats.pop_front();
          in_tvalid <= 1'b1;
          wait_cnt <= (sent % 100 < 30) ? 0 : $urandom_range(0, 16);
        end else stim_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    in_tready_s <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      expected_quats.push_back(matrix_to_quat(in_tdata));
      sent <= sent + 1;
    end
  end

  // One long hold-off of the receiver once 40 items have been sent.
  always @(negedge clk) begin
    if (rst_n && !hold_off && sent >= 40) begin
      hold_off <= 1'b1;
      hold_cnt <= 200;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Receiver, with a gap drawn after every transfer, random except in the first 30 of every 100 items.
  always @(negedge clk) begin
    int rx_gap;
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_cnt > 0 || (!hold_off && sent >= 40)) out_tready <= 1'b0;
    else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_tready <= 1'b0;
    end else if (out_xfer_s) begin
      rx_gap = (sent % 100 < 30) ? 0 : $urandom_range(0, 16);
      if (rx_gap == 0) out_tready <= 1'b1;
      else begin
        out_tready <= 1'b0;
        stall_cnt <= rx_gap - 1;
      end
    end else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    quat_t exp_q;
    quat_t got_q;
    int n_bad;
    n_bad = 0;
    out_xfer_s <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      for (int i = 0; i < 4; i++) got_q.q[i] = out_tdata[i*DW +: DW];
      got_q.idx = idx_t'(out_tuser[1:0]);
      if (expected_quats.size() == 0) begin
        $error("unexpected output transfer: tdata %h", out_tdata);
        errors <= errors + 1;
      end else begin
        exp_q = expected_quats.pop_front();
        matched <= matched + 1;
        branch_seen[exp_q.idx] <= branch_seen[exp_q.idx] + 1;
        if (got_q.q[0] !== exp_q.q[0]) begin
          $error("qw expected %0d actual %0d", exp_q.q[0], got_q.q[0]);
          n_bad++;
        end
        if (got_q.q[1] !== exp_q.q[1]) begin
          $error("qx expected %0d actual %0d", exp_q.q[1], got_q.q[1]);
          n_bad++;
        end
        if (got_q.q[2] !== exp_q.q[2]) begin
          $error("qy expected %0d actual %0d", exp_q.q[2], got_q.q[2]);
          n_bad++;
        end
        if (got_q.q[3] !== exp_q.q[3]) begin
          $error("qz expected %0d actual %0d", exp_q.q[3], got_q.q[3]);
          n_bad++;
        end
        if (got_q.idx !== exp_q.idx) begin
          $error("largest_index expected %0d actual %0d", exp_q.idx, got_q.idx);
          n_bad++;
        end
        errors <= errors + n_bad;
      end
    end
  end

  initial begin
    wait (stim_done && !in_tvalid && expected_quats.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d quaternions; branches w/x/y/z taken %0d/%0d/%0d/%0d times.",
             matched, branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3]);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("[rotation_matrix_to_quaternion_unit] OK");
    end else begin
      $display("[rotation_matrix_to_quaternion_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[rotation_matrix_to_quaternion_unit] ERROR");
    $finish;
  end

endmodule
